@@ design/dwf_pkg.sv @@
package dwf_pkg;

   // Request function codes.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Response status codes.
   localparam logic [2:0] STATUS_QUEUED = 3'd0;
   localparam logic [2:0] STATUS_DUP    = 3'd1;
   localparam logic [2:0] STATUS_FULL   = 3'd2;
   localparam logic [2:0] STATUS_POPPED = 3'd3;
   localparam logic [2:0] STATUS_EMPTY  = 3'd4;

   // One queued work entry as it sits in the entry memory.
   typedef struct packed {
      logic [31:0] handler;
      logic [31:0] argument;
   } entry_type;

   // Request transaction payload.
   typedef struct packed {
      logic        func;
      logic [31:0] handler_addr;
      logic [31:0] argument;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_handler;
      logic [31:0] out_argument;
      logic [3:0]  fill_level;
   } rsp_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP_READ,
      ST_FINISH
   } state_type;

endpackage

@@ design/dwf_entry_ram.sv @@
module dwf_entry_ram
   import dwf_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dedup_work_fifo.sv @@
// Work queue with duplicate suppression.
// The req_ channel carries one transaction per request: a push of a handler
// address and argument pair, or a pop of the oldest entry. The rsp_ channel
// returns exactly one transaction per request with a status, the popped
// pair (zero unless popped) and the fill level after the request.
// A push reads every queued entry from the entry memory, one read per cycle
// starting at the head, and compares each against the new pair; a duplicate
// found early ends the scan sooner. A pop reads the head entry and then
// finishes; an empty pop finishes without a memory read. The entry memory
// has a single read port, so entries are read one at a time. One request
// is in flight at a time; req_ready is high only while the sequencer idles,
// so the next request can be taken in the cycle after the response is loaded.
// The response sits in an output register, so a new request is accepted
// and worked on while an earlier response waits for rsp_ready. If the
// receiver stalls, the finished result is held until the register frees.
// Reset empties the queue at once; the entry memory itself is not cleared,
// as only written entries are ever read.
module dedup_work_fifo
   import dwf_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   entry_type      key_ff, key_in;
   logic [AW-1:0]  rd_slot_ff, rd_slot_in;
   logic [AW-1:0]  wr_slot_ff, wr_slot_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  scan_addr_ff, scan_addr_in;
   logic [CW-1:0]  scan_left_ff, scan_left_in;
   logic           pend_ff, pend_in;
   logic [2:0]     res_status_ff, res_status_in;
   entry_type      res_entry_ff, res_entry_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           mem_we;
   logic [AW-1:0]  mem_rd_addr;
   entry_type      mem_rd_data;
   logic           hit;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] slot);
      logic [AW-1:0] nxt;
      if (slot == AW'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + AW'(1);
      end
      return nxt;
   endfunction

   dwf_entry_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_slot_ff),
      .wr_data (key_ff),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_slot_ff   <= '0;
         wr_slot_ff   <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_slot_ff   <= rd_slot_in;
         wr_slot_ff   <= wr_slot_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      scan_addr_ff  <= scan_addr_in;
      scan_left_ff  <= scan_left_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The entry read last cycle matches the pushed pair.
   assign hit = pend_ff && (mem_rd_data == key_ff);

   // Sequencer: next state, memory access and result capture.
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      rd_slot_in    = rd_slot_ff;
      wr_slot_in    = wr_slot_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      pend_in       = 1'b0;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_we        = 1'b0;
      mem_rd_addr   = scan_addr_ff;

      // The receiver took the waiting response.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = '{handler: req_data.handler_addr, argument: req_data.argument};
               if (req_data.func == FUNC_PUSH) begin
                  scan_addr_in = rd_slot_ff;
                  scan_left_in = count_ff;
                  state_in     = ST_SCAN;
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  res_entry_in  = '0;
                  state_in      = ST_FINISH;
               end else begin
                  mem_rd_addr = rd_slot_ff;
                  state_in    = ST_POP_READ;
               end
            end
         end

         ST_SCAN: begin
            priority if (hit) begin
               res_status_in = STATUS_DUP;
               res_entry_in  = '0;
               state_in      = ST_FINISH;
            end else if (scan_left_ff != '0) begin
               // Issue the next read; its data is compared next cycle.
               mem_rd_addr  = scan_addr_ff;
               scan_addr_in = slot_inc(scan_addr_ff);
               scan_left_in = scan_left_ff - CW'(1);
               pend_in      = 1'b1;
            end else if (count_ff == CW'(DEPTH)) begin
               res_status_in = STATUS_FULL;
               res_entry_in  = '0;
               state_in      = ST_FINISH;
            end else begin
               mem_we        = 1'b1;
               wr_slot_in    = slot_inc(wr_slot_ff);
               count_in      = count_ff + CW'(1);
               res_status_in = STATUS_QUEUED;
               res_entry_in  = '0;
               state_in      = ST_FINISH;
            end
         end

         ST_POP_READ: begin
            res_status_in = STATUS_POPPED;
            res_entry_in  = mem_rd_data;
            rd_slot_in    = slot_inc(rd_slot_ff);
            count_in      = count_ff - CW'(1);
            state_in      = ST_FINISH;
         end

         ST_FINISH: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.out_handler  = res_entry_ff.handler;
               rsp_data_in.out_argument = res_entry_ff.argument;
               rsp_data_in.fill_level   = 4'(count_ff);
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/dwf_checker.sv @@
module dwf_checker
   import dwf_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Only one request transaction is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // Only a pop returns a nonzero entry.
   a_zero_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_POPPED) |->
         (rsp_data.out_handler == '0) && (rsp_data.out_argument == '0))
      else $error("entry data on a response that is not a pop");

   // An empty pop reports an empty queue.
   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_EMPTY) |-> rsp_data.fill_level == '0)
      else $error("empty status with nonzero fill level");

   // A full overflow reports a full queue.
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
         rsp_data.fill_level == 4'(DEPTH))
      else $error("overflow status without a full queue");

endmodule

bind dedup_work_fifo dwf_checker #(.DEPTH(DEPTH)) u_dwf_checker (.*);
